// ----- design/upq_pkg.sv -----
// ----------------------------------------------------------------------------
// upq_pkg: shared types and constants for the unsorted max priority queue
// Entry, request and response words, command and status codes, cell ops.
// ----------------------------------------------------------------------------
package upq_pkg;

  localparam int DEPTH = 16;
  localparam int IDXW  = $clog2(DEPTH);
  localparam int CNTW  = $clog2(DEPTH + 1);

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic               command;
    logic signed [31:0] value;
    logic signed [31:0] priority_req;
  } upq_req_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic signed [31:0] out_value;
    logic signed [31:0] out_priority;
  } upq_rsp_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] prio;
  } upq_entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT,
    CELL_LOAD
  } upq_cell_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_CLOSE
  } upq_state_t;

endpackage

// ----- design/upq_cell.sv -----
// ----------------------------------------------------------------------------
// upq_cell: one storage cell of the queue chain
// Holds one entry; takes the neighbor's entry on shift or a new entry on load.
// ----------------------------------------------------------------------------
module upq_cell (
  input  logic                 clk,
  input  upq_pkg::upq_cell_op_t op,
  input  upq_pkg::upq_entry_t  load_data,
  input  upq_pkg::upq_entry_t  next_data,
  output upq_pkg::upq_entry_t  data
);
  import upq_pkg::*;

  always_ff @(posedge clk) begin
    case (op)
      CELL_SHIFT: data <= next_data;
      CELL_LOAD:  data <= load_data;
      default:    data <= data;
    endcase
  end

endmodule

// ----- design/unsorted_max_priority_queue_core.sv -----
// ----------------------------------------------------------------------------
// unsorted_max_priority_queue_core: max priority queue on a ring of cells
// Push: done follows start in the next cycle. Pop on empty: likewise.
// Pop: S_SCAN rotates the ring one full turn past one comparator, then S_CLOSE
// closes the gap and sets done (registered); no new word is taken until S_IDLE.
// Reset (rst, synchronous): queue empty, controller idle, no result pending.
// Results carry no backpressure: done is a one-cycle strobe.
// ----------------------------------------------------------------------------
module unsorted_max_priority_queue_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  upq_pkg::upq_req_t request,
  output logic              busy,
  output logic              done,
  output upq_pkg::upq_rsp_t response
);
  import upq_pkg::*;

  upq_state_t          state, state_next;
  logic [IDXW-1:0]     step, step_next;
  logic [CNTW-1:0]     count, count_next;
  logic [IDXW-1:0]     best_idx, best_idx_next;
  upq_entry_t          best, best_next;
  logic                done_next;
  upq_rsp_t            response_next;
  logic                push_en, rotate, close;
  upq_entry_t          push_data;
  upq_entry_t          cell_data [DEPTH];
  upq_cell_op_t        cell_op [DEPTH];

  assign push_data.value = request.value;
  assign push_data.prio  = request.priority_req;
  assign busy            = (state != S_IDLE);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam int NB = (i + 1) % DEPTH;

    always_comb begin
      if (push_en && (count[IDXW-1:0] == IDXW'(i))) begin
        cell_op[i] = CELL_LOAD;
      end else if (rotate) begin
        cell_op[i] = CELL_SHIFT;
      end else if (close && (IDXW'(i) >= best_idx)) begin
        cell_op[i] = CELL_SHIFT;
      end else begin
        cell_op[i] = CELL_HOLD;
      end
    end

    upq_cell u_cell (
      .clk       (clk),
      .op        (cell_op[i]),
      .load_data (push_data),
      .next_data (cell_data[NB]),
      .data      (cell_data[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
    step     <= step_next;
    best_idx <= best_idx_next;
    best     <= best_next;
    response <= response_next;
  end

  always_comb begin
    state_next    = state;
    step_next     = step;
    count_next    = count;
    best_idx_next = best_idx;
    best_next     = best;
    done_next     = 1'b0;
    response_next = response;
    push_en       = 1'b0;
    rotate        = 1'b0;
    close         = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          response_next.status       = STAT_OK;
          response_next.out_value    = '0;
          response_next.out_priority = '0;
          if (request.command == CMD_PUSH) begin
            done_next = 1'b1;
            if (count == CNTW'(DEPTH)) begin
              response_next.status = STAT_FULL;
            end else begin
              push_en    = 1'b1;
              count_next = count + 1'b1;
            end
          end else if (count == '0) begin
            done_next            = 1'b1;
            response_next.status = STAT_EMPTY;
          end else begin
            step_next  = '0;
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        rotate = 1'b1;
        // cell 0 shows the entry with original index step
        if ((step == '0) ||
            ((CNTW'(step) < count) && (cell_data[0].prio > best.prio))) begin
          best_next     = cell_data[0];
          best_idx_next = step;
        end
        if (step == IDXW'(DEPTH - 1)) begin
          state_next = S_CLOSE;
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_CLOSE: begin
        close                      = 1'b1;
        count_next                 = count - 1'b1;
        done_next                  = 1'b1;
        response_next.status       = STAT_OK;
        response_next.out_value    = best.value;
        response_next.out_priority = best.prio;
        state_next                 = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- design/upq_checker.sv -----
// ----------------------------------------------------------------------------
// upq_checker: port-level checks for the unsorted max priority queue
// Watches command words and result strobes on the top level ports.
// ----------------------------------------------------------------------------
module upq_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input upq_pkg::upq_req_t request,
  input logic              busy,
  input logic              done,
  input upq_pkg::upq_rsp_t response
);
  import upq_pkg::*;

  a_push_done: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (request.command == CMD_PUSH) |=> done && !busy)
    else $error("push word not answered in one cycle");

  a_pop_progress: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (request.command == CMD_POP) |=> done || busy)
    else $error("pop word neither answered nor in progress");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (response.status == STAT_OK) || (response.status == STAT_EMPTY) ||
             (response.status == STAT_FULL))
    else $error("undefined status code");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && (response.status != STAT_OK) |->
      (response.out_value == '0) && (response.out_priority == '0))
    else $error("failed word carries nonzero payload");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("pop finished without result");

endmodule

bind unsorted_max_priority_queue_core upq_checker u_upq_checker (.*);

// ----- sim/tb_unsorted_max_priority_queue_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_unsorted_max_priority_queue_core: self-checking bench for the queue core
// Sends push and pop words with random idle gaps and predicts every response
// from a local model of the queue. Each strobed response is compared field by
// field with the oldest prediction. Covers empty and full queues, extreme
// values and priorities, ties and long random push/pop mixes.
// ----------------------------------------------------------------------------
module tb_unsorted_max_priority_queue_core;
  import upq_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic     clk = 1'b0;
  logic     rst;
  logic     start;
  upq_req_t request;
  logic     busy;
  logic     done;
  upq_rsp_t response;

  upq_entry_t queue_model[$];
  upq_rsp_t   pending_responses[$];
  int         error_count = 0;
  int         cycle_count = 0;
  int         max_gap = 16;

  unsorted_max_priority_queue_core uut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .request  (request),
    .busy     (busy),
    .done     (done),
    .response (response)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want,
             cycle_count);
    error_count++;
  endtask

  function automatic upq_rsp_t predict_response(input upq_req_t w);
    upq_rsp_t   r;
    upq_entry_t e;
    int         best;
    r = '0;
    r.status = STAT_OK;
    if (w.command == CMD_PUSH) begin
      if (queue_model.size() >= DEPTH) begin
        r.status = STAT_FULL;
      end else begin
        e.value = w.value;
        e.prio  = w.priority_req;
        queue_model.push_back(e);
      end
    end else if (queue_model.size() == 0) begin
      r.status = STAT_EMPTY;
    end else begin
      best = 0;
      for (int i = 1; i < queue_model.size(); i++)
        if ($signed(queue_model[i].prio) > $signed(queue_model[best].prio)) best = i;
      r.out_value    = queue_model[best].value;
      r.out_priority = queue_model[best].prio;
      queue_model.delete(best);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    upq_rsp_t want;
    if (!rst && done) begin
      if (pending_responses.size() == 0) begin
        report_mismatch("unexpected word", {30'd0, response.status}, '0);
      end else begin
        want = pending_responses.pop_front();
        if (response.status !== want.status)
          report_mismatch("status", {30'd0, response.status}, {30'd0, want.status});
        if (response.out_value !== want.out_value)
          report_mismatch("out_value", response.out_value, want.out_value);
        if (response.out_priority !== want.out_priority)
          report_mismatch("out_priority", response.out_priority, want.out_priority);
      end
    end
  end

  // start stays high after acceptance; the next word or hold_off settles it
  task automatic issue_word(input upq_req_t w);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    request <= w;
    do @(posedge clk); while (busy);
    pending_responses.push_back(predict_response(w));
  endtask

  task automatic hold_off();
    start <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
  endtask

  function automatic upq_req_t make_word(input logic cmd, input logic [31:0] val,
                                         input logic [31:0] prio);
    upq_req_t w;
    w.command      = cmd;
    w.value        = val;
    w.priority_req = prio;
    return w;
  endfunction

  function automatic logic [31:0] draw_priority();
    case ($urandom_range(0, 3))
      0: return 32'(int'($urandom_range(0, 7)) - 4);
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic test_pop_empty();
    issue_word(make_word(CMD_POP, 32'h7fff_ffff, 32'h8000_0000));
  endtask

  task automatic test_fill_extremes();
    logic [31:0] prios [16];
    logic [31:0] val;
    prios = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff,
              32'h7fff_ffff, 32'd3, 32'd3, 32'h8000_0000,
              32'h0, 32'd3, 32'hffff_ffff, 32'h7fff_ffff,
              32'd1, 32'd2, 32'd3, 32'h8000_0000};
    for (int i = 0; i < DEPTH; i++) begin
      case (i)
        0: val = 32'h7fff_ffff;
        1: val = 32'h8000_0000;
        2: val = 32'h0;
        3: val = 32'hffff_ffff;
        default: val = $urandom;
      endcase
      issue_word(make_word(CMD_PUSH, val, prios[i % 16]));
    end
  endtask

  task automatic test_push_full();
    issue_word(make_word(CMD_PUSH, 32'hffff_ffff, 32'h7fff_ffff));
  endtask

  task automatic test_pop_order();
    for (int i = 0; i < 4; i++)
      issue_word(make_word(CMD_POP, $urandom, $urandom));
  endtask

  task automatic test_random_mix(input int count, input int push_pct, input int gap);
    max_gap = gap;
    for (int i = 0; i < count; i++)
      issue_word(make_word(($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP,
                           $urandom, draw_priority()));
  endtask

  initial begin
    rst     = 1'b1;
    start   = 1'b0;
    request = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_pop_empty();
    test_fill_extremes();
    test_push_full();
    test_pop_order();
    test_random_mix(300, 70, 16);
    test_random_mix(250, 50, 0);
    hold_off();
    test_random_mix(250, 30, 16);
    test_random_mix(300, 60, 16);

    hold_off();
    repeat (DEPTH + 4) @(posedge clk);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/upq_pkg.sv
design/upq_cell.sv
design/unsorted_max_priority_queue_core.sv
design/upq_checker.sv
sim/tb_unsorted_max_priority_queue_core.sv
